FILE: hw/rtl/jlr_pkg.sv
// ---------------------------------------------------------------------------
// jlr_pkg: shared types and constants for the joystick LED ring
// Ring size, field widths, register indexes, sequencer states and the
// request/response bundle of the trail divider.
// ---------------------------------------------------------------------------
package jlr_pkg;

	localparam int LED_COUNT = 32;
	localparam int POS_W     = 6;
	localparam int TRAIL_W   = 5;
	localparam int CH_W      = 8;
	localparam int SMP_W     = 10;
	localparam int TIME_W    = 32;
	localparam int TRAIL_MAX = LED_COUNT / 2 - 2;

	// trail divider: numerator c*(L-k+1), denominator 5*L, quotient < 2^CH_W/5
	localparam int NUM_W = CH_W + TRAIL_W;
	localparam int DEN_W = TRAIL_W + 3;
	localparam int QUO_W = CH_W - 2;

	// rate delay slopes and base
	localparam logic [SMP_W-1:0] TRAIL_SLOPE = SMP_W'(900);
	localparam logic [SMP_W-1:0] MOVE_SLOPE  = SMP_W'(960);
	localparam logic [SMP_W:0]   DELAY_BASE  = (SMP_W + 1)'(1000);

	// configuration register indexes
	localparam logic [2:0] CFG_X_CENTER      = 3'd0;
	localparam logic [2:0] CFG_Y_CENTER      = 3'd1;
	localparam logic [2:0] CFG_X_HIGH        = 3'd2;
	localparam logic [2:0] CFG_X_LOW         = 3'd3;
	localparam logic [2:0] CFG_Y_HIGH        = 3'd4;
	localparam logic [2:0] CFG_Y_LOW         = 3'd5;
	localparam logic [2:0] CFG_COLOR_PERIOD  = 3'd6;
	localparam logic [2:0] CFG_REDRAW_PERIOD = 3'd7;

	// colour channel codes
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// trail side bits
	localparam logic [1:0] SIDE_LEFT  = 2'b01;
	localparam logic [1:0] SIDE_RIGHT = 2'b10;
	localparam logic [1:0] SIDE_BOTH  = 2'b11;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRAIL,
		S_COLOR,
		S_MOVE,
		S_PIX,
		S_START,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CH_W-1:0]  quo;
	} div_rsp_t;

endpackage

FILE: hw/rtl/jlr_div.sv
// ---------------------------------------------------------------------------
// jlr_div: radix-2 restoring divider for trail brightness
// One compare and subtract per cycle; the quotient is known to fit QUO_W bits.
// ---------------------------------------------------------------------------
module jlr_div
	import jlr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int SH_W  = DEN_W + QUO_W - 1;
	localparam int CMP_W = (SH_W > NUM_W) ? SH_W : NUM_W;
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [NUM_W-1:0] rem_q;
	logic [SH_W-1:0]  den_sh_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	assign fits = CMP_W'(rem_q) >= CMP_W'(den_sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load, then one quotient bit per cycle, MSB first
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q    <= req.num;
			den_sh_q <= SH_W'(req.den) << (QUO_W - 1);
			quo_q    <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - NUM_W'(den_sh_q);
			end
			quo_q    <= {quo_q[QUO_W-2:0], fits};
			den_sh_q <= den_sh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = CH_W'(quo_q);

endmodule

FILE: hw/rtl/joystick_led_ring_dot_trail_unit.sv
// ---------------------------------------------------------------------------
// joystick_led_ring_dot_trail_unit: joystick-driven LED ring dot with trail
// Takes one tick word (time, joystick, pots), updates trail length, colour and
// dot position, and streams a full frame of pixels on a move or idle redraw.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tick word: now_ms, joy_x, joy_y, pots
//  m_*     | out | m_tvalid/m_tready  | pixel word: led_index, rgb; tlast
//  cfg_*   | in  | cfg_valid/cfg_ready| register index and 10-bit data
//
//  A trail pixel costs three 6-step divisions through the one shared divider,
//  one per colour channel, before its pixel word goes out. s_tready is high
//  only in idle. A stall on m_tready holds the pixel word and the sequencer.
//  Reset clears the block state and the sequencer and loads the register
//  defaults; no clearing pass is needed. cfg_ready is always high.
// ---------------------------------------------------------------------------
module joystick_led_ring_dot_trail_unit
	import jlr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// tick in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // now_ms[31:0], joy_x[41:32], joy_y[51:42],
	                               // pot_red[61:52], pot_blue[71:62],
	                               // pot_green[81:72], zero pad [87:82]
	// pixels out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // led_index[5:0], red[13:6], green[21:14],
	                               // blue[29:22], zero pad [31:30]
	output logic        m_tlast,   // frame_last
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	// configuration registers
	logic [SMP_W-1:0] x_center_q, y_center_q, x_high_q, x_low_q;
	logic [SMP_W-1:0] y_high_q, y_low_q, color_period_q, redraw_period_q;

	// block state
	logic [POS_W-1:0]   dot_q;
	logic [TRAIL_W-1:0] trail_q;
	logic [CH_W-1:0]    col_r_q, col_g_q, col_b_q;
	logic [TIME_W-1:0]  last_trail_q, last_color_q, last_move_q;

	// latched tick
	logic [TIME_W-1:0] now_q;
	logic [SMP_W-1:0]  jx_q, jy_q, pr_q, pb_q, pg_q;

	// frame sequencer
	state_t             state_q, state_d;
	logic [1:0]         side_q;
	logic [POS_W-1:0]   pix_q;
	logic [TRAIL_W-1:0] k_q;
	logic [1:0]         ch_q;
	logic [CH_W-1:0]    out_r_q, out_g_q, out_b_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic s_fire, m_fire, cfg_fire;
	assign s_fire   = s_tvalid & s_tready;
	assign m_fire   = m_tvalid & m_tready;
	assign cfg_fire = cfg_valid & cfg_ready;
	assign cfg_ready = 1'b1;

	// ---- shared rate unit: elapsed time and delay = 1000 - slope*dev/512 ----
	logic [SMP_W-1:0]   ru_sample, ru_center, ru_slope, ru_dev, ru_delay;
	logic [2*SMP_W-1:0] ru_prod;
	logic [SMP_W:0]     ru_drop;
	logic [TIME_W-1:0]  ru_last, elapsed;
	logic               rate_due, color_due, redraw_due;

	always_comb begin
		ru_sample = jy_q;
		ru_center = y_center_q;
		ru_slope  = TRAIL_SLOPE;
		ru_last   = last_trail_q;
		unique case (state_q)
			S_COLOR: begin
				ru_last = last_color_q;
			end
			S_MOVE: begin
				ru_sample = jx_q;
				ru_center = x_center_q;
				ru_slope  = MOVE_SLOPE;
				ru_last   = last_move_q;
			end
			default: ;
		endcase
	end

	assign ru_dev   = (ru_sample > ru_center) ? ru_sample - ru_center : ru_center - ru_sample;
	assign ru_prod  = (2*SMP_W)'(ru_dev) * (2*SMP_W)'(ru_slope);
	assign ru_drop  = ru_prod[2*SMP_W-1:9];
	// a negative delay counts as zero
	assign ru_delay = (ru_drop >= DELAY_BASE) ? '0 : SMP_W'(DELAY_BASE - ru_drop);
	assign elapsed  = now_q - ru_last;   // wraps modulo 2^32

	assign rate_due   = elapsed >= TIME_W'(ru_delay);
	assign color_due  = elapsed >= TIME_W'(color_period_q);
	assign redraw_due = elapsed >= TIME_W'(redraw_period_q);

	// ---- pixel classification ----
	logic [POS_W:0] dist_r, dist_l;
	logic           is_dot, in_right, in_left, last_pix;

	assign dist_r = (pix_q >= dot_q) ? (POS_W + 1)'(pix_q - dot_q)
	                                 : (POS_W + 1)'(LED_COUNT) + (POS_W + 1)'(pix_q)
	                                   - (POS_W + 1)'(dot_q);
	assign dist_l = (dot_q >= pix_q) ? (POS_W + 1)'(dot_q - pix_q)
	                                 : (POS_W + 1)'(LED_COUNT) + (POS_W + 1)'(dot_q)
	                                   - (POS_W + 1)'(pix_q);
	assign is_dot   = pix_q == dot_q;
	assign in_right = side_q[1] && (trail_q != '0) && (dist_r != '0)
	                  && (dist_r <= (POS_W + 1)'(trail_q));
	assign in_left  = side_q[0] && (trail_q != '0) && (dist_l != '0)
	                  && (dist_l <= (POS_W + 1)'(trail_q));
	assign last_pix = pix_q == POS_W'(LED_COUNT - 1);

	// ---- divider request: channel * (L - k + 1) over 5 * L ----
	logic [CH_W-1:0]    ch_val;
	logic [TRAIL_W-1:0] weight;

	always_comb begin
		case (ch_q)
			CH_RED:   ch_val = col_r_q;
			CH_GREEN: ch_val = col_g_q;
			default:  ch_val = col_b_q;
		endcase
	end

	assign weight        = trail_q - k_q + TRAIL_W'(1);
	assign div_req.start = state_q == S_START;
	assign div_req.num   = NUM_W'(ch_val) * NUM_W'(weight);
	assign div_req.den   = (DEN_W'(trail_q) << 2) + DEN_W'(trail_q);

	jlr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---- sequencer next state ----
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_TRAIL;
				end
			end
			S_TRAIL: state_d = S_COLOR;
			S_COLOR: state_d = S_MOVE;
			S_MOVE: begin
				if (rate_due) begin
					state_d = S_PIX;
				end else if (redraw_due && (jx_q < x_high_q) && (jx_q > x_low_q)) begin
					state_d = S_PIX;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_PIX: begin
				if (!is_dot && (in_right || in_left)) begin
					state_d = S_START;
				end else begin
					state_d = S_OUT;
				end
			end
			S_START: state_d = S_DIV;
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = (ch_q == CH_BLUE) ? S_OUT : S_START;
				end
			end
			S_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = last_pix ? S_IDLE : S_PIX;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---- register writes ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_center_q      <= SMP_W'(520);
			y_center_q      <= SMP_W'(532);
			x_high_q        <= SMP_W'(530);
			x_low_q         <= SMP_W'(500);
			y_high_q        <= SMP_W'(550);
			y_low_q         <= SMP_W'(500);
			color_period_q  <= SMP_W'(10);
			redraw_period_q <= SMP_W'(20);
		end else if (cfg_fire) begin
			unique case (cfg_index)
				CFG_X_CENTER:      x_center_q      <= cfg_data;
				CFG_Y_CENTER:      y_center_q      <= cfg_data;
				CFG_X_HIGH:        x_high_q        <= cfg_data;
				CFG_X_LOW:         x_low_q         <= cfg_data;
				CFG_Y_HIGH:        y_high_q        <= cfg_data;
				CFG_Y_LOW:         y_low_q         <= cfg_data;
				CFG_COLOR_PERIOD:  color_period_q  <= cfg_data;
				CFG_REDRAW_PERIOD: redraw_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- block state: trail, colour, dot, timestamps ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q        <= '0;
			trail_q      <= '0;
			col_r_q      <= '0;
			col_g_q      <= '0;
			col_b_q      <= '0;
			last_trail_q <= '0;
			last_color_q <= '0;
			last_move_q  <= '0;
			side_q       <= SIDE_BOTH;
			pix_q        <= '0;
		end else begin
			case (state_q)
				S_TRAIL: begin
					// grow or shrink, saturating at both ends
					if (rate_due) begin
						last_trail_q <= now_q;
						if (jy_q > y_high_q) begin
							if (trail_q < TRAIL_W'(TRAIL_MAX)) begin
								trail_q <= trail_q + TRAIL_W'(1);
							end else begin
								trail_q <= TRAIL_W'(TRAIL_MAX);
							end
						end else if (jy_q < y_low_q) begin
							if (trail_q != '0) begin
								trail_q <= trail_q - TRAIL_W'(1);
							end
						end
					end
				end
				S_COLOR: begin
					// resample pots, dropping two bits
					if (color_due) begin
						last_color_q <= now_q;
						col_r_q      <= pr_q[SMP_W-1:2];
						col_b_q      <= pb_q[SMP_W-1:2];
						col_g_q      <= pg_q[SMP_W-1:2];
					end
				end
				S_MOVE: begin
					pix_q  <= '0;
					side_q <= SIDE_BOTH;
					if (rate_due) begin
						last_move_q <= now_q;
						if (jx_q > x_high_q) begin
							dot_q  <= (dot_q == POS_W'(LED_COUNT - 1)) ? '0
							          : dot_q + POS_W'(1);
							side_q <= SIDE_LEFT;
						end else if (jx_q < x_low_q) begin
							dot_q  <= (dot_q == '0) ? POS_W'(LED_COUNT - 1)
							          : dot_q - POS_W'(1);
							side_q <= SIDE_RIGHT;
						end
					end
				end
				S_OUT: begin
					if (m_fire && !last_pix) begin
						pix_q <= pix_q + POS_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// ---- tick latch and pixel datapath ----
	always_ff @(posedge clk) begin
		if (s_fire) begin
			now_q <= s_tdata[31:0];
			jx_q  <= s_tdata[41:32];
			jy_q  <= s_tdata[51:42];
			pr_q  <= s_tdata[61:52];
			pb_q  <= s_tdata[71:62];
			pg_q  <= s_tdata[81:72];
		end
		case (state_q)
			S_PIX: begin
				ch_q <= CH_RED;
				// right trail wins where both reach
				k_q  <= in_right ? TRAIL_W'(dist_r) : TRAIL_W'(dist_l);
				if (is_dot) begin
					out_r_q <= col_r_q;
					out_g_q <= col_g_q;
					out_b_q <= col_b_q;
				end else begin
					out_r_q <= '0;
					out_g_q <= '0;
					out_b_q <= '0;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					case (ch_q)
						CH_RED:   out_r_q <= div_rsp.quo;
						CH_GREEN: out_g_q <= div_rsp.quo;
						default:  out_b_q <= div_rsp.quo;
					endcase
					ch_q <= ch_q + 2'd1;
				end
			end
			default: ;
		endcase
	end

	assign m_tdata = {2'b00, out_b_q, out_g_q, out_r_q, pix_q};
	assign m_tlast = last_pix;

endmodule
